@@ design/isd_pkg.sv @@
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants of the IMU step detector: axis numbering,
// register indexes, fixed-point coefficients and the step phase encoding.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int NUM_AXES   = 6;
  localparam int ACCEL_AXES = 3;
  localparam int AXIS_Z     = 2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ACCEL_OFFSET_X = 3'd0;
  localparam logic [2:0] REG_ACCEL_OFFSET_Y = 3'd1;
  localparam logic [2:0] REG_ACCEL_OFFSET_Z = 3'd2;
  localparam logic [2:0] REG_GYRO_OFFSET_X  = 3'd3;
  localparam logic [2:0] REG_GYRO_OFFSET_Y  = 3'd4;
  localparam logic [2:0] REG_GYRO_OFFSET_Z  = 3'd5;
  localparam logic [2:0] REG_STEP_HIGH      = 3'd6;
  localparam logic [2:0] REG_STEP_LOW       = 3'd7;

  localparam logic [14:0] STEP_HIGH_RESET = 15'd5325;
  localparam logic [14:0] STEP_LOW_RESET  = 15'd3686;

  // Fixed-point coefficients (Q16 fractions).
  localparam logic signed [14:0] AXIS_COEF   = 15'sd9830;
  localparam logic signed [12:0] ENERGY_COEF = 13'sd3277;
  localparam logic [14:0]        GYRO_COEF   = 15'd25575;

  localparam logic [27:0]        ENERGY_MAX   = 28'hFFF_FFFF;
  localparam logic [27:0]        MOTION_LIMIT = 28'd32768;
  localparam logic signed [25:0] PEAK_HYST    = 26'sd209715;
  localparam logic [31:0]        STEP_MIN_US  = 32'd400000;
  localparam logic [31:0]        STEP_MAX_US  = 32'd1200000;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RISING  = 2'd1,
    PH_PEAK    = 2'd2,
    PH_FALLING = 2'd3
  } phase_t;

  // Side information that travels with an item down the pipeline.
  typedef struct packed {
    logic [31:0] ts;
    logic        clr;
  } item_info_t;

  // Status handed from the energy stage to the step state machine.
  typedef struct packed {
    logic signed [24:0] az;
    logic               active;
  } motion_t;

endpackage

@@ design/isd_window.sv @@
// ----------------------------------------------------------------------------
// isd_window
// Offset subtraction with 16-bit saturation, per-axis sample windows and a
// rank-based median of each window after the new sample is written.
// ----------------------------------------------------------------------------
module isd_window #(
  parameter int WINDOW_DEPTH = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [15:0] raw    [isd_pkg::NUM_AXES],
  input  logic signed [15:0] offset [isd_pkg::NUM_AXES],
  output logic signed [15:0] med_r  [isd_pkg::NUM_AXES]
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int RANK_W = $clog2(WINDOW_DEPTH);
  localparam int MID    = WINDOW_DEPTH / 2;

  logic signed [15:0] win_r   [isd_pkg::NUM_AXES][WINDOW_DEPTH];
  logic signed [15:0] win_nxt [isd_pkg::NUM_AXES][WINDOW_DEPTH];
  logic signed [15:0] sat     [isd_pkg::NUM_AXES];
  logic signed [16:0] diff    [isd_pkg::NUM_AXES];
  logic signed [15:0] med_nxt [isd_pkg::NUM_AXES];
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic               primed_r;

  always_comb begin
    for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
      diff[a] = {raw[a][15], raw[a]} - {offset[a][15], offset[a]};
      if (diff[a][16] != diff[a][15]) begin
        sat[a] = diff[a][16] ? 16'sh8000 : 16'sh7FFF;
      end else begin
        sat[a] = diff[a][15:0];
      end
    end
  end

  // The first sample after reset fills the whole window.
  always_comb begin
    for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        win_nxt[a][k] = (!primed_r || slot_r == SLOT_W'(k)) ? sat[a] : win_r[a][k];
      end
    end
  end

  assign slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;

  // Each element gets a unique rank, ties broken by position; the element
  // whose rank is the middle one is the median.
  always_comb begin
    logic [RANK_W-1:0] rank;
    rank = '0;
    for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
      med_nxt[a] = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        rank = '0;
        for (int j = 0; j < WINDOW_DEPTH; j++) begin
          if ((win_nxt[a][j] < win_nxt[a][i]) ||
              (win_nxt[a][j] == win_nxt[a][i] && j < i)) begin
            rank = rank + 1'b1;
          end
        end
        if (rank == RANK_W'(MID)) begin
          med_nxt[a] = win_nxt[a][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      primed_r <= 1'b0;
    end else if (load) begin
      slot_r   <= slot_nxt;
      primed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win_r <= win_nxt;
      med_r <= med_nxt;
    end
  end

endmodule

@@ design/isd_smooth.sv @@
// ----------------------------------------------------------------------------
// isd_smooth
// Exponential smoothing (alpha 0.15) of each axis median, held with nine
// fraction bits; the median is passed along with the smoothed value.
// ----------------------------------------------------------------------------
module isd_smooth (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  logic signed [15:0] med    [isd_pkg::NUM_AXES],
  output logic signed [24:0] sm_r   [isd_pkg::NUM_AXES],
  output logic signed [15:0] med_r  [isd_pkg::NUM_AXES]
);

  logic signed [25:0] diff   [isd_pkg::NUM_AXES];
  logic signed [40:0] prod   [isd_pkg::NUM_AXES];
  logic signed [40:0] rnd    [isd_pkg::NUM_AXES];
  logic signed [24:0] sm_nxt [isd_pkg::NUM_AXES];

  always_comb begin
    for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
      diff[a]   = {med[a][15], med[a], 9'd0} - {sm_r[a][24], sm_r[a]};
      prod[a]   = diff[a] * isd_pkg::AXIS_COEF;
      rnd[a]    = prod[a] + 41'sd32768;
      sm_nxt[a] = sm_r[a] + rnd[a][40:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
        sm_r[a] <= '0;
      end
    end else if (load) begin
      sm_r <= sm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      med_r <= med;
    end
  end

endmodule

@@ design/isd_energy.sv @@
// ----------------------------------------------------------------------------
// isd_energy
// Motion energy: deviation of each median from its smoothed value, gyro
// terms scaled into acceleration units, then an EMA (alpha 0.05) clamped
// to 28 bits. Two stages: deviation sum, then the energy update.
// ----------------------------------------------------------------------------
module isd_energy (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_dev,
  input  logic                  load_ema,
  input  logic signed [24:0]    sm  [isd_pkg::NUM_AXES],
  input  logic signed [15:0]    med [isd_pkg::NUM_AXES],
  output isd_pkg::motion_t      motion
);

  logic signed [25:0] dev   [isd_pkg::NUM_AXES];
  logic [24:0]        mag   [isd_pkg::NUM_AXES];
  logic [25:0]        asum  [isd_pkg::NUM_AXES];
  logic [39:0]        gprod [isd_pkg::NUM_AXES];
  logic [39:0]        gsum  [isd_pkg::NUM_AXES];
  logic [27:0]        part  [isd_pkg::NUM_AXES];
  logic [27:0]        ein_nxt;
  logic [27:0]        ein_r;
  logic signed [24:0] az_c_r;

  logic signed [28:0] ediff;
  logic signed [41:0] eprod;
  logic signed [41:0] ernd;
  logic signed [29:0] esum;
  logic [27:0]        energy_nxt;
  logic [27:0]        energy_r;
  logic signed [24:0] az_d_r;
  logic               active_r;

  always_comb begin
    ein_nxt = '0;
    for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
      dev[a]   = {med[a][15], med[a], 9'd0} - {sm[a][24], sm[a]};
      mag[a]   = dev[a][25] ? 25'(-dev[a]) : dev[a][24:0];
      asum[a]  = {1'b0, mag[a]} + 26'd16;
      gprod[a] = mag[a] * isd_pkg::GYRO_COEF;
      gsum[a]  = gprod[a] + 40'd32768;
      if (a < isd_pkg::ACCEL_AXES) begin
        part[a] = 28'(asum[a][25:5]);
      end else begin
        part[a] = 28'(gsum[a][39:16]);
      end
      ein_nxt = ein_nxt + part[a];
    end
  end

  always_comb begin
    ediff = $signed({1'b0, ein_r}) - $signed({1'b0, energy_r});
    eprod = ediff * isd_pkg::ENERGY_COEF;
    ernd  = eprod + 42'sd32768;
    esum  = $signed({2'b00, energy_r}) + {{4{ernd[41]}}, ernd[41:16]};
    if (esum < 0) begin
      energy_nxt = '0;
    end else if (esum > $signed({2'b00, isd_pkg::ENERGY_MAX})) begin
      energy_nxt = isd_pkg::ENERGY_MAX;
    end else begin
      energy_nxt = esum[27:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= '0;
    end else if (load_ema) begin
      energy_r <= energy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_dev) begin
      ein_r  <= ein_nxt;
      az_c_r <= sm[isd_pkg::AXIS_Z];
    end
    if (load_ema) begin
      az_d_r   <= az_c_r;
      active_r <= energy_nxt > isd_pkg::MOTION_LIMIT;
    end
  end

  assign motion.az     = az_d_r;
  assign motion.active = active_r;

endmodule

@@ design/isd_step_fsm.sv @@
// ----------------------------------------------------------------------------
// isd_step_fsm
// Idle/rising/peak/falling step state machine on the smoothed Z axis, with
// the daily and total step counters and the result register.
// ----------------------------------------------------------------------------
module isd_step_fsm #(
  parameter int COUNT_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  isd_pkg::item_info_t    info,
  input  isd_pkg::motion_t       motion,
  input  logic [14:0]            high_level,
  input  logic [14:0]            low_level,
  output logic                   step_detected,
  output logic [COUNT_BITS-1:0]  daily_steps,
  output logic [COUNT_BITS-1:0]  total_steps,
  output logic [1:0]             step_phase,
  output logic                   motion_active,
  output logic                   persist_request
);

  isd_pkg::phase_t phase_r, phase_nxt;

  logic signed [24:0]    peak_r, peak_nxt;
  logic [31:0]           start_r, start_nxt;
  logic [COUNT_BITS-1:0] daily_r, daily_nxt, daily_base;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [3:0]            d10_r, d10_nxt, d10_base;
  logic                  step_r, persist_r, active_r;

  logic [31:0]           elapsed;
  logic signed [25:0]    peak_floor;
  logic                  az_above_hi, az_below_lo, az_above_peak, az_below_floor;
  logic                  count_step;

  assign elapsed        = info.ts - start_r;
  assign peak_floor     = {peak_r[24], peak_r} - isd_pkg::PEAK_HYST;
  assign az_above_hi    = motion.az > $signed({1'b0, high_level, 9'd0});
  assign az_below_lo    = motion.az < $signed({1'b0, low_level, 9'd0});
  assign az_above_peak  = motion.az > peak_r;
  assign az_below_floor = $signed({motion.az[24], motion.az}) < peak_floor;
  assign count_step     = (phase_r == isd_pkg::PH_FALLING) && az_below_lo &&
                          (elapsed > isd_pkg::STEP_MIN_US);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      isd_pkg::PH_IDLE: begin
        if (az_above_hi && motion.active) phase_nxt = isd_pkg::PH_RISING;
      end
      isd_pkg::PH_RISING: begin
        // The timeout wins over a move to peak in the same sample.
        if (elapsed > isd_pkg::STEP_MAX_US) begin
          phase_nxt = isd_pkg::PH_IDLE;
        end else if (!az_above_peak && az_below_floor) begin
          phase_nxt = isd_pkg::PH_PEAK;
        end
      end
      isd_pkg::PH_PEAK: begin
        if (az_below_lo) phase_nxt = isd_pkg::PH_FALLING;
      end
      isd_pkg::PH_FALLING: begin
        if (count_step) phase_nxt = isd_pkg::PH_IDLE;
      end
      default: phase_nxt = isd_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    peak_nxt  = peak_r;
    start_nxt = start_r;
    if (phase_r == isd_pkg::PH_IDLE && az_above_hi && motion.active) begin
      peak_nxt  = motion.az;
      start_nxt = info.ts;
    end else if (phase_r == isd_pkg::PH_RISING && az_above_peak) begin
      peak_nxt = motion.az;
    end

    // The daily clear applies before this sample's step. d10 follows the
    // daily count modulo ten, including across a counter wrap.
    daily_base = info.clr ? '0 : daily_r;
    d10_base   = info.clr ? '0 : d10_r;
    daily_nxt  = daily_base;
    d10_nxt    = d10_base;
    total_nxt  = total_r;
    if (count_step) begin
      daily_nxt = daily_base + 1'b1;
      total_nxt = total_r + 1'b1;
      if (daily_base == '1 || d10_base == 4'd9) begin
        d10_nxt = '0;
      end else begin
        d10_nxt = d10_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= isd_pkg::PH_IDLE;
      peak_r  <= '0;
      start_r <= '0;
      daily_r <= '0;
      total_r <= '0;
      d10_r   <= '0;
    end else if (load) begin
      phase_r <= phase_nxt;
      peak_r  <= peak_nxt;
      start_r <= start_nxt;
      daily_r <= daily_nxt;
      total_r <= total_nxt;
      d10_r   <= d10_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step_r    <= count_step;
      persist_r <= count_step && (d10_nxt == 4'd0);
      active_r  <= motion.active;
    end
  end

  assign step_detected   = step_r;
  assign daily_steps     = daily_r;
  assign total_steps     = total_r;
  assign step_phase      = phase_r;
  assign motion_active   = active_r;
  assign persist_request = persist_r;

endmodule

@@ design/imu_step_detector.sv @@
// ----------------------------------------------------------------------------
// imu_step_detector
// Step counter on a six-axis IMU sample stream with median filtering.
// ----------------------------------------------------------------------------
// Usage:
// Each item on the in_ channel is one raw sample (three acceleration axes,
// three rotation-rate axes, a microsecond time stamp and a daily-clear flag).
// Each accepted item produces exactly one result item on the out_ channel:
// the step flag, the daily and total counts, the step phase, the motion flag
// and a persistence request every ten daily steps.
// Calibration offsets and step levels are written through the cfg_ port,
// which is always ready; write it only while no item is in flight.
// Each item passes through the stage registers in order; the result is
// presented from the last one. Throughput: one item per cycle while
// out_ready holds. The work is split over five register stages (window
// and median, axis smoothing, deviation sum, energy update, step state machine).
// Reset clears the windows' primed flag, the filters, the state machine and
// both counters; the first sample after reset fills the whole window.
// When the receiver stalls, the result holds and the pipeline keeps taking
// items until every stage is full; then in_ready drops.
// ----------------------------------------------------------------------------
module imu_step_detector #(
  parameter int WINDOW_DEPTH = 5,
  parameter int COUNT_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_accel_x,
  input  logic signed [15:0]    in_accel_y,
  input  logic signed [15:0]    in_accel_z,
  input  logic signed [15:0]    in_gyro_x,
  input  logic signed [15:0]    in_gyro_y,
  input  logic signed [15:0]    in_gyro_z,
  input  logic [31:0]           in_timestamp_us,
  input  logic                  in_clear_daily,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_step_detected,
  output logic [COUNT_BITS-1:0] out_daily_steps,
  output logic [COUNT_BITS-1:0] out_total_steps,
  output logic [1:0]            out_step_phase,
  output logic                  out_motion_active,
  output logic                  out_persist_request,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // Configuration registers.
  logic signed [15:0] offset_r [isd_pkg::NUM_AXES];
  logic [14:0]        high_r;
  logic [14:0]        low_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < isd_pkg::NUM_AXES; a++) begin
        offset_r[a] <= '0;
      end
      high_r <= isd_pkg::STEP_HIGH_RESET;
      low_r  <= isd_pkg::STEP_LOW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        isd_pkg::REG_ACCEL_OFFSET_X: offset_r[0] <= cfg_data;
        isd_pkg::REG_ACCEL_OFFSET_Y: offset_r[1] <= cfg_data;
        isd_pkg::REG_ACCEL_OFFSET_Z: offset_r[2] <= cfg_data;
        isd_pkg::REG_GYRO_OFFSET_X:  offset_r[3] <= cfg_data;
        isd_pkg::REG_GYRO_OFFSET_Y:  offset_r[4] <= cfg_data;
        isd_pkg::REG_GYRO_OFFSET_Z:  offset_r[5] <= cfg_data;
        isd_pkg::REG_STEP_HIGH:      high_r      <= cfg_data[14:0];
        isd_pkg::REG_STEP_LOW:       low_r       <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy. A stage can take a new item when it is empty or
  // its own item moves on in the same cycle.
  logic va_r, vb_r, vc_r, vd_r, vo_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
  logic load_a, load_b, load_c, load_d, load_o;

  assign rdy_o  = !vo_r || out_ready;
  assign rdy_d  = !vd_r || rdy_o;
  assign rdy_c  = !vc_r || rdy_d;
  assign rdy_b  = !vb_r || rdy_c;
  assign rdy_a  = !va_r || rdy_b;

  assign load_a = in_valid && rdy_a;
  assign load_b = va_r && rdy_b;
  assign load_c = vb_r && rdy_c;
  assign load_d = vc_r && rdy_d;
  assign load_o = vd_r && rdy_o;

  assign in_ready  = rdy_a;
  assign out_valid = vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
      if (rdy_o) vo_r <= vd_r;
    end
  end

  // Time stamp and clear flag ride along with the item.
  isd_pkg::item_info_t info_a_r, info_b_r, info_c_r, info_d_r;

  always_ff @(posedge clk) begin
    if (load_a) begin
      info_a_r.ts  <= in_timestamp_us;
      info_a_r.clr <= in_clear_daily;
    end
    if (load_b) info_b_r <= info_a_r;
    if (load_c) info_c_r <= info_b_r;
    if (load_d) info_d_r <= info_c_r;
  end

  logic signed [15:0] raw   [isd_pkg::NUM_AXES];
  logic signed [15:0] med_a [isd_pkg::NUM_AXES];
  logic signed [15:0] med_b [isd_pkg::NUM_AXES];
  logic signed [24:0] sm_b  [isd_pkg::NUM_AXES];
  isd_pkg::motion_t   motion_d;

  assign raw[0] = in_accel_x;
  assign raw[1] = in_accel_y;
  assign raw[2] = in_accel_z;
  assign raw[3] = in_gyro_x;
  assign raw[4] = in_gyro_y;
  assign raw[5] = in_gyro_z;

  isd_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load_a),
    .raw    (raw),
    .offset (offset_r),
    .med_r  (med_a)
  );

  isd_smooth u_smooth (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load_b),
    .med   (med_a),
    .sm_r  (sm_b),
    .med_r (med_b)
  );

  isd_energy u_energy (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_dev (load_c),
    .load_ema (load_d),
    .sm       (sm_b),
    .med      (med_b),
    .motion   (motion_d)
  );

  isd_step_fsm #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step_fsm (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load_o),
    .info            (info_d_r),
    .motion          (motion_d),
    .high_level      (high_r),
    .low_level       (low_r),
    .step_detected   (out_step_detected),
    .daily_steps     (out_daily_steps),
    .total_steps     (out_total_steps),
    .step_phase      (out_step_phase),
    .motion_active   (out_motion_active),
    .persist_request (out_persist_request)
  );

endmodule
